[design/vps_pkg.sv]
// shared widths, types and register codes for the verlet particle step block
package vps_pkg;

    // coordinate format and fixed operand widths
    localparam int COORD_W   = 48;
    localparam int MASS_W    = 32;
    localparam int DT_W      = 32;
    localparam int MASS_FRAC = 16;
    localparam int REST_W    = 48;
    localparam int AXES      = 3;

    // widest configuration register sets the write data width
    localparam int CFG_W = (REST_W > DT_W) ? REST_W : DT_W;

    // step path: exact difference, small components squared
    localparam int STEP_W  = COORD_W + 1;
    localparam int SMALL_W = REST_W / 2;
    localparam int SQ_W    = 2 * SMALL_W;
    localparam int SQSUM_W = SQ_W + 2;

    // acceleration path: split product, quotient and signed term
    localparam int HALF_W   = COORD_W / 2;
    localparam int PPLO_W   = HALF_W + DT_W;
    localparam int PPHI_W   = (COORD_W - HALF_W) + DT_W;
    localparam int PROD_W   = COORD_W + DT_W;
    localparam int NUM_W    = PROD_W - MASS_FRAC;
    localparam int ACC_W    = NUM_W + 1;
    localparam int SUM_W    = ACC_W + 2;

    // pipeline depths
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_LAT  = 4;
    localparam int ACC_LAT   = DIV_STEPS + 4;
    localparam int DLY_LEN   = ACC_LAT - STEP_LAT;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [STEP_W-1:0]  t_step;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic [MASS_W-1:0]         t_mass;
    typedef logic [DT_W-1:0]           t_dt;
    typedef logic [REST_W-1:0]         t_rest;
    typedef logic [CFG_W-1:0]          t_cfg_data;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_DT_SQ   = 1'b0,
        CFG_REST_SQ = 1'b1
    } t_cfg_idx;

    localparam t_dt   DT_SQ_RESET   = t_dt'(1193046);
    localparam t_rest REST_SQ_RESET = '0;

    // sideband carried alongside the quotient
    typedef struct packed {
        logic neg;
        logic mass_zero;
    } t_div_side;

    typedef struct packed {
        t_coord pos_x;
        t_coord pos_y;
        t_coord pos_z;
        t_coord prior_x;
        t_coord prior_y;
        t_coord prior_z;
        t_coord force_x;
        t_coord force_y;
        t_coord force_z;
        t_mass  mass;
    } t_in_item;

    typedef struct packed {
        t_coord new_x;
        t_coord new_y;
        t_coord new_z;
        t_coord next_prior_x;
        t_coord next_prior_y;
        t_coord next_prior_z;
    } t_out_item;

endpackage

[design/verlet_particle_step_top.sv]
// verlet particle step: top level with input stage, alignment line and saturating sum
// a taken item passes the input stage, 68 stage lanes and output register to its strobe
// throughput: one item per cycle if not busy; depth: 64-stage restoring divider per axis
// reset: config returns to defaults, all in-flight items are dropped, busy is high for
// one cycle after reset and low from then on; results cannot be stalled by the receiver
module verlet_particle_step_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  vps_pkg::t_in_item    i_item,
    output logic                 o_strobe,
    output vps_pkg::t_out_item   o_result,
    input  logic                 i_cfg_we,
    input  vps_pkg::t_cfg_idx    i_cfg_idx,
    input  vps_pkg::t_cfg_data   i_cfg_data
);
    import vps_pkg::*;

    typedef struct packed {
        t_coord [AXES-1:0] pos;
        t_step  [AXES-1:0] step;
    } t_dly_item;

    logic               r_busy;
    t_dt                r_dt_sq;
    t_rest              r_rest_sq;
    t_in_item           r_in;
    logic               r_v0;
    logic [ACC_LAT-1:0] r_vld;
    t_dly_item          r_dly [DLY_LEN];
    logic               r_strobe;
    t_out_item          r_out;

    logic               accept;
    t_coord             in_pos   [AXES];
    t_coord             in_prior [AXES];
    t_coord             in_force [AXES];
    t_coord             st_pos   [AXES];
    t_step              st_step  [AXES];
    t_acc               acc      [AXES];
    t_dly_item          n_dly;
    t_coord             n_new    [AXES];
    t_coord             al_pos   [AXES];

    assign accept = i_start & ~r_busy;
    assign o_busy = r_busy;

    // busy only in the cycle right after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt_sq   <= DT_SQ_RESET;
            r_rest_sq <= REST_SQ_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DT_SQ: begin
                    r_dt_sq <= i_cfg_data[DT_W-1:0];
                end
                CFG_REST_SQ: begin
                    r_rest_sq <= i_cfg_data[REST_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        r_in <= i_item;
    end

    // valid bits follow the items down the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_vld <= '0;
        end else begin
            r_v0  <= accept;
            r_vld <= {r_vld[ACC_LAT-2:0], r_v0};
        end
    end

    assign in_pos[0]   = r_in.pos_x;
    assign in_pos[1]   = r_in.pos_y;
    assign in_pos[2]   = r_in.pos_z;
    assign in_prior[0] = r_in.prior_x;
    assign in_prior[1] = r_in.prior_y;
    assign in_prior[2] = r_in.prior_z;
    assign in_force[0] = r_in.force_x;
    assign in_force[1] = r_in.force_y;
    assign in_force[2] = r_in.force_z;

    vps_step u_step (
        .i_clk   (i_clk),
        .i_pos   (in_pos),
        .i_prior (in_prior),
        .i_rest  (r_rest_sq),
        .o_pos   (st_pos),
        .o_step  (st_step)
    );

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        vps_accel u_accel (
            .i_clk   (i_clk),
            .i_force (in_force[a]),
            .i_mass  (r_in.mass),
            .i_dt    (r_dt_sq),
            .o_acc   (acc[a])
        );
    end

    // hold position and step until the acceleration terms arrive
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_dly.pos[a]  = st_pos[a];
            n_dly.step[a] = st_step[a];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dly[0] <= n_dly;
        for (int k = 1; k < DLY_LEN; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    // position + step + acceleration, saturated to the coordinate range
    always_comb begin
        logic [SUM_W-1:0]         total;
        logic [SUM_W-COORD_W:0]   hi;
        for (int a = 0; a < AXES; a++) begin
            al_pos[a] = t_coord'(r_dly[DLY_LEN-1].pos[a]);
            total     = SUM_W'(al_pos[a])
                      + SUM_W'(t_step'(r_dly[DLY_LEN-1].step[a]))
                      + SUM_W'(acc[a]);
            hi        = total[SUM_W-1:COORD_W-1];
            if ((&hi) | ~(|hi)) begin
                n_new[a] = t_coord'(total[COORD_W-1:0]);
            end else if (total[SUM_W-1]) begin
                n_new[a] = t_coord'({1'b1, {(COORD_W-1){1'b0}}});
            end else begin
                n_new[a] = t_coord'({1'b0, {(COORD_W-1){1'b1}}});
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld[ACC_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.new_x        <= n_new[0];
        r_out.new_y        <= n_new[1];
        r_out.new_z        <= n_new[2];
        r_out.next_prior_x <= al_pos[0];
        r_out.next_prior_y <= al_pos[1];
        r_out.next_prior_z <= al_pos[2];
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

[design/vps_div.sv]
// pipelined restoring divider, one quotient bit per stage
module vps_div (
    input  logic                    i_clk,
    input  logic [vps_pkg::NUM_W-1:0] i_num,
    input  vps_pkg::t_mass          i_mass,
    input  vps_pkg::t_div_side      i_side,
    output logic [vps_pkg::NUM_W-1:0] o_quo,
    output vps_pkg::t_div_side      o_side
);
    import vps_pkg::*;

    // per stage: numerator bits still to go, quotient bits shifted in at the bottom
    logic [NUM_W-1:0]  r_work [DIV_STEPS];
    logic [MASS_W-1:0] r_rem  [DIV_STEPS];
    t_mass             r_mass [DIV_STEPS];
    t_div_side         r_side [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
        logic [NUM_W-1:0]  w_in;
        logic [MASS_W-1:0] rem_in;
        t_mass             m_in;
        t_div_side         s_in;
        logic [MASS_W:0]   trial;
        logic [MASS_W:0]   diff;
        logic              ge;
        logic [NUM_W-1:0]  n_work;
        logic [MASS_W-1:0] n_rem;

        if (k == 0) begin : g_first
            assign w_in   = i_num;
            assign rem_in = '0;
            assign m_in   = i_mass;
            assign s_in   = i_side;
        end else begin : g_next
            assign w_in   = r_work[k-1];
            assign rem_in = r_rem[k-1];
            assign m_in   = r_mass[k-1];
            assign s_in   = r_side[k-1];
        end

        // trial subtract; the borrow bit says the divisor did not fit
        always_comb begin
            trial  = {rem_in, w_in[NUM_W-1]};
            diff   = trial - {1'b0, m_in};
            ge     = ~diff[MASS_W];
            n_rem  = ge ? diff[MASS_W-1:0] : trial[MASS_W-1:0];
            n_work = {w_in[NUM_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            r_work[k] <= n_work;
            r_rem[k]  <= n_rem;
            r_mass[k] <= m_in;
            r_side[k] <= s_in;
        end
    end

    assign o_quo  = r_work[DIV_STEPS-1];
    assign o_side = r_side[DIV_STEPS-1];

endmodule

[design/vps_accel.sv]
// acceleration term of one axis: force * dt^2 / mass, signed, zero for zero mass
module vps_accel (
    input  logic            i_clk,
    input  vps_pkg::t_coord i_force,
    input  vps_pkg::t_mass  i_mass,
    input  vps_pkg::t_dt    i_dt,
    output vps_pkg::t_acc   o_acc
);
    import vps_pkg::*;

    logic [COORD_W-1:0] r_fmag;
    t_dt                r_dt1;
    t_mass              r_mass1;
    t_div_side          r_side1;

    logic [PPLO_W-1:0]  r_pp_lo;
    logic [PPHI_W-1:0]  r_pp_hi;
    t_mass              r_mass2;
    t_div_side          r_side2;

    logic [NUM_W-1:0]   r_num;
    t_mass              r_mass3;
    t_div_side          r_side3;

    t_acc               r_acc;

    logic [COORD_W-1:0] n_fmag;
    t_div_side          n_side1;
    logic [PPLO_W-1:0]  n_pp_lo;
    logic [PPHI_W-1:0]  n_pp_hi;
    logic [PROD_W-1:0]  n_prod;
    logic [NUM_W-1:0]   quo;
    t_div_side          quo_side;
    t_acc               quo_ext;
    t_acc               n_acc;

    // force magnitude and sign
    always_comb begin
        n_fmag            = i_force[COORD_W-1] ? COORD_W'(-i_force) : COORD_W'(i_force);
        n_side1.neg       = i_force[COORD_W-1];
        n_side1.mass_zero = (i_mass == '0);
    end

    always_ff @(posedge i_clk) begin
        r_fmag  <= n_fmag;
        r_dt1   <= i_dt;
        r_mass1 <= i_mass;
        r_side1 <= n_side1;
    end

    // two half-width partial products
    always_comb begin
        n_pp_lo = PPLO_W'(r_fmag[HALF_W-1:0]) * PPLO_W'(r_dt1);
        n_pp_hi = PPHI_W'(r_fmag[COORD_W-1:HALF_W]) * PPHI_W'(r_dt1);
    end

    always_ff @(posedge i_clk) begin
        r_pp_lo <= n_pp_lo;
        r_pp_hi <= n_pp_hi;
        r_mass2 <= r_mass1;
        r_side2 <= r_side1;
    end

    // combine partial products, drop the mass fraction bits
    always_comb begin
        n_prod = (PROD_W'(r_pp_hi) << HALF_W) + PROD_W'(r_pp_lo);
    end

    always_ff @(posedge i_clk) begin
        r_num   <= n_prod[PROD_W-1:MASS_FRAC];
        r_mass3 <= r_mass2;
        r_side3 <= r_side2;
    end

    vps_div u_div (
        .i_clk  (i_clk),
        .i_num  (r_num),
        .i_mass (r_mass3),
        .i_side (r_side3),
        .o_quo  (quo),
        .o_side (quo_side)
    );

    // restore sign, zero mass gives no acceleration
    always_comb begin
        quo_ext = t_acc'({1'b0, quo});
        if (quo_side.mass_zero) begin
            n_acc = '0;
        end else if (quo_side.neg) begin
            n_acc = -quo_ext;
        end else begin
            n_acc = quo_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

[design/vps_step.sv]
// step vector with rest check on its squared length
module vps_step (
    input  logic            i_clk,
    input  vps_pkg::t_coord i_pos   [vps_pkg::AXES],
    input  vps_pkg::t_coord i_prior [vps_pkg::AXES],
    input  vps_pkg::t_rest  i_rest,
    output vps_pkg::t_coord o_pos   [vps_pkg::AXES],
    output vps_pkg::t_step  o_step  [vps_pkg::AXES]
);
    import vps_pkg::*;

    t_step              r_d1    [AXES];
    t_coord             r_pos1  [AXES];
    logic [SMALL_W-1:0] r_small2 [AXES];
    logic               r_big2;
    t_step              r_d2    [AXES];
    t_coord             r_pos2  [AXES];
    logic [SQ_W-1:0]    r_sq3   [AXES];
    logic               r_big3;
    t_step              r_d3    [AXES];
    t_coord             r_pos3  [AXES];
    t_step              r_step4 [AXES];
    t_coord             r_pos4  [AXES];

    t_step              n_d1    [AXES];
    logic [STEP_W-1:0]  n_mag   [AXES];
    logic               n_big2;
    logic [SQ_W-1:0]    n_sq3   [AXES];
    logic [SQSUM_W-1:0] n_sum;
    logic               n_rest;

    // exact difference, one bit wider than a coordinate
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_d1[a] = STEP_W'(i_pos[a]) - STEP_W'(i_prior[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1   <= n_d1;
        r_pos1 <= i_pos;
    end

    // magnitudes; any large component keeps the particle moving
    always_comb begin
        n_big2 = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            n_mag[a] = r_d1[a][STEP_W-1] ? STEP_W'(-r_d1[a]) : STEP_W'(r_d1[a]);
            n_big2   = n_big2 | (|n_mag[a][STEP_W-1:SMALL_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < AXES; a++) begin
            r_small2[a] <= n_mag[a][SMALL_W-1:0];
        end
        r_big2 <= n_big2;
        r_d2   <= r_d1;
        r_pos2 <= r_pos1;
    end

    // squares of the small components
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_sq3[a] = SQ_W'(r_small2[a]) * SQ_W'(r_small2[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq3  <= n_sq3;
        r_big3 <= r_big2;
        r_d3   <= r_d2;
        r_pos3 <= r_pos2;
    end

    // sum and threshold compare, zero the step at rest
    always_comb begin
        n_sum = '0;
        for (int a = 0; a < AXES; a++) begin
            n_sum = n_sum + SQSUM_W'(r_sq3[a]);
        end
        n_rest = ~r_big3 && (n_sum < SQSUM_W'(i_rest));
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < AXES; a++) begin
            r_step4[a] <= n_rest ? t_step'(0) : r_d3[a];
        end
        r_pos4 <= r_pos3;
    end

    assign o_pos  = r_pos4;
    assign o_step = r_step4;

endmodule

[tb/testbench.sv]
// testbench for verlet_particle_step_top: random and directed particle items against a predictor
`timescale 1ns / 1ps

module testbench;
    import vps_pkg::*;

    localparam int     OUT_FIELDS = 2 * AXES;
    localparam int     IDLE_PCT   = 38;
    localparam t_coord C_MAX      = t_coord'({1'b0, {(COORD_W-1){1'b1}}});
    localparam t_coord C_MIN      = t_coord'({1'b1, {(COORD_W-1){1'b0}}});

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_start    = 1'b0;
    t_in_item   i_item     = '0;
    logic       i_cfg_we   = 1'b0;
    t_cfg_idx   i_cfg_idx  = CFG_DT_SQ;
    t_cfg_data  i_cfg_data = '0;
    logic       o_busy;
    logic       o_strobe;
    t_out_item  o_result;

    // register copies used by the predictor
    t_dt        cur_dt_sq   = DT_SQ_RESET;
    t_rest      cur_rest_sq = REST_SQ_RESET;

    t_in_item   particle_queue[$];
    t_out_item  pending_updates[$];
    int         error_count = 0;
    bit         steady      = 1'b0;
    string      field_names[OUT_FIELDS] = '{"new_x", "new_y", "new_z",
                                            "next_prior_x", "next_prior_y", "next_prior_z"};

    verlet_particle_step_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // one verlet step: exact step, rest test, force*dt^2/mass, saturating sum
    function automatic t_out_item predict_particle_step(t_in_item it, t_dt dt_sq, t_rest rest_sq);
        t_coord              pos[AXES];
        t_coord              prev[AXES];
        t_coord              frc[AXES];
        t_coord              upd[AXES];
        logic signed [127:0] step[AXES];
        logic signed [127:0] total;
        logic signed [127:0] fw;
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        logic [127:0]        mag;
        logic [127:0]        len_sq;
        logic [127:0]        quo;
        logic                far;
        logic                still;
        t_out_item           res;
        pos  = '{it.pos_x, it.pos_y, it.pos_z};
        prev = '{it.prior_x, it.prior_y, it.prior_z};
        frc  = '{it.force_x, it.force_y, it.force_z};
        hi_lim = {{(128-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
        lo_lim = -hi_lim - 1;
        len_sq = '0;
        far    = 1'b0;
        // squared step length, any component of 2^24 or more is never at rest
        for (int a = 0; a < AXES; a++) begin
            step[a] = pos[a];
            step[a] = step[a] - prev[a];
            mag = step[a][127] ? -step[a] : step[a];
            if (mag >= (128'd1 << 24))
                far = 1'b1;
            else
                len_sq = len_sq + mag * mag;
        end
        still = !far && (len_sq < 128'(rest_sq));
        for (int a = 0; a < AXES; a++) begin
            total = pos[a];
            if (!still)
                total = total + step[a];
            // acceleration term truncated toward zero, skipped for zero mass
            if (it.mass != '0) begin
                fw  = frc[a];
                mag = fw[127] ? -fw : fw;
                quo = (mag * 128'(dt_sq)) / (128'(it.mass) << MASS_FRAC);
                if (fw[127])
                    quo = -quo;
                total = total + $signed(quo);
            end
            if (total > hi_lim)
                upd[a] = hi_lim[COORD_W-1:0];
            else if (total < lo_lim)
                upd[a] = lo_lim[COORD_W-1:0];
            else
                upd[a] = total[COORD_W-1:0];
        end
        res.new_x        = upd[0];
        res.new_y        = upd[1];
        res.new_z        = upd[2];
        res.next_prior_x = it.pos_x;
        res.next_prior_y = it.pos_y;
        res.next_prior_z = it.pos_z;
        return res;
    endfunction

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= 200)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // append an item to the pending stimulus
    task automatic queue_particle(t_in_item it);
        particle_queue = {particle_queue, it};
    endtask

    // signed value from -2^k to 2^k - 1
    function automatic t_coord rand_small(int k);
        t_coord v;
        v = t_coord'({$urandom(), $urandom()});
        return v >>> (COORD_W - 1 - k);
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(9))
            0, 1, 2, 3: return t_coord'({$urandom(), $urandom()});
            4, 5, 6:    return rand_small($urandom_range(30));
            7:          return C_MAX - t_coord'($urandom_range(3));
            8:          return C_MIN + t_coord'($urandom_range(3));
            default:    return $urandom_range(1) ? t_coord'(0) : t_coord'(-1);
        endcase
    endfunction

    // previous position mostly a short step behind the current one
    function automatic t_coord rand_prior(t_coord p, int mode, int k);
        case (mode)
            7:       return rand_coord();
            8:       return p;
            9:       return p - rand_small($urandom_range(COORD_W - 1));
            default: return p - rand_small(k);
        endcase
    endfunction

    function automatic t_mass rand_mass();
        case ($urandom_range(9))
            0:       return '0;
            1:       return t_mass'(1);
            2:       return '1;
            3:       return t_mass'(1) << MASS_FRAC;
            4, 5:    return t_mass'($urandom());
            default: return t_mass'($urandom()) >> $urandom_range(MASS_W - 1);
        endcase
    endfunction

    function automatic t_in_item rand_particle();
        t_in_item it;
        int       mode;
        int       k;
        mode = $urandom_range(9);
        k    = $urandom_range(26);
        it.pos_x   = rand_coord();
        it.pos_y   = rand_coord();
        it.pos_z   = rand_coord();
        it.prior_x = rand_prior(it.pos_x, mode, k);
        it.prior_y = rand_prior(it.pos_y, mode, k);
        it.prior_z = rand_prior(it.pos_z, mode, k);
        it.force_x = rand_coord();
        it.force_y = rand_coord();
        it.force_z = rand_coord();
        it.mass    = rand_mass();
        return it;
    endfunction

    function automatic t_in_item make_particle(t_coord px, t_coord py, t_coord pz,
                                               t_coord qx, t_coord qy, t_coord qz,
                                               t_coord fx, t_coord fy, t_coord fz, t_mass m);
        t_in_item it;
        it = '{px, py, pz, qx, qy, qz, fx, fy, fz, m};
        return it;
    endfunction

    // register shadow follows the write port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_dt_sq   <= DT_SQ_RESET;
            cur_rest_sq <= REST_SQ_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DT_SQ:   cur_dt_sq   <= t_dt'(i_cfg_data);
                CFG_REST_SQ: cur_rest_sq <= t_rest'(i_cfg_data);
                default:     ;
            endcase
        end
    end

    // driver: predict on acceptance, then present the next item or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy)
                pending_updates = {pending_updates,
                                   predict_particle_step(i_item, cur_dt_sq, cur_rest_sq)};
            if (!i_start || !o_busy) begin
                if (particle_queue.size() != 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    i_start <= 1'b1;
                    i_item  <= particle_queue.pop_front();
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobe is matched against the oldest predicted update
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_updates.size() == 0) begin
                report_error("result strobed with no item outstanding");
            end else begin
                want = pending_updates.pop_front();
                for (int k = 0; k < OUT_FIELDS; k++) begin
                    if (o_result[(OUT_FIELDS-1-k)*COORD_W +: COORD_W] !==
                        want[(OUT_FIELDS-1-k)*COORD_W +: COORD_W])
                        report_error($sformatf("%s got %0d expected %0d", field_names[k],
                            $signed(o_result[(OUT_FIELDS-1-k)*COORD_W +: COORD_W]),
                            $signed(want[(OUT_FIELDS-1-k)*COORD_W +: COORD_W])));
                end
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, t_cfg_data val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // sampled mid-cycle so driver updates have settled
    task automatic wait_drained();
        while (particle_queue.size() != 0 || i_start || pending_updates.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(t_dt dt, t_rest rest, int count);
        write_reg(CFG_DT_SQ, t_cfg_data'(dt));
        write_reg(CFG_REST_SQ, t_cfg_data'(rest));
        repeat (count) queue_particle(rand_particle());
        wait_drained();
    endtask

    // stimulus sequence
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, zero threshold: saturation, zero mass, extreme force and mass
        queue_particle(make_particle(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_particle(make_particle(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN,
                                     0, 0, 0, 0));
        queue_particle(make_particle(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                                     0, 0, 0, 0));
        queue_particle(make_particle(C_MAX, C_MAX - 1, 5, C_MAX - 1, C_MAX, 5,
                                     0, 0, 0, 0));
        queue_particle(make_particle(1000, -1000, 7, 1000, -1000, 7,
                                     C_MAX, C_MIN, C_MAX, 1));
        queue_particle(make_particle(1000, -1000, 7, 1000, -1000, 7,
                                     C_MIN, C_MAX, -1, 1));
        queue_particle(make_particle(3, 4, 5, 1, 2, 3, C_MAX, C_MIN, 1, '1));
        queue_particle(make_particle(-5, 6, -7, 0, 0, 0, -1, 1, -1,
                                     t_mass'(1) << MASS_FRAC));
        queue_particle(make_particle(9, 9, 9, 1, 1, 1, C_MAX, C_MIN, C_MAX, 0));
        queue_particle(make_particle(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                     C_MIN, C_MIN, C_MIN, 1));
        queue_particle(make_particle(48'sh1234_5678_9ABC, -48'sh0FED_CBA9_8765, 1,
                                     48'sh1234_5678_9000, -48'sh0FED_CBA9_0000, 0,
                                     48'sh0000_0001_0000, -48'sh0000_0002_8000,
                                     48'sh7FFF_0000_0000, 32'h0003_0000));
        queue_particle(make_particle(0, 0, 0, 0, 0, 0, 1, -1, 2, 1));
        queue_particle(make_particle(-1, 0, 1, 0, -1, 0, -3, 3, -7, 7));
        queue_particle(make_particle(-1, -1, -1, 0, 0, 0, 1, 1, 1, 2));
        wait_drained();

        // threshold of 100 with steps just below, at and above it
        write_reg(CFG_DT_SQ, t_cfg_data'(32'hFFFF_FFFF));
        write_reg(CFG_REST_SQ, t_cfg_data'(100));
        queue_particle(make_particle(9, 3, 3, 0, 0, 0, 0, 0, 0, 0));
        queue_particle(make_particle(10, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_particle(make_particle(-10, -1, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_particle(make_particle(9, 3, 3, 0, 0, 0, C_MAX, C_MIN, 5, '1));
        wait_drained();

        // largest threshold against the 2^24 component boundary
        write_reg(CFG_DT_SQ, '0);
        write_reg(CFG_REST_SQ, t_cfg_data'({REST_W{1'b1}}));
        queue_particle(make_particle(48'sd16777215, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_particle(make_particle(-48'sd16777216, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_particle(make_particle(48'sd16777215, 48'sd16777215, 48'sd16777215,
                                     0, 0, 0, 0, 0, 0, 0));
        queue_particle(make_particle(-48'sd16777215, 0, 0, 0, 0, 0, C_MAX, 1, -1, 1));
        wait_drained();

        // random items across several register settings
        run_phase(DT_SQ_RESET, '0, 225);
        run_phase('1, '1, 225);
        run_phase('0, t_rest'(1) << 30, 225);
        steady = 1'b1;
        run_phase(t_dt'(1), t_rest'(1) << 40, 225);
        steady = 1'b0;
        run_phase(t_dt'($urandom()), t_rest'(1) << $urandom_range(REST_W - 1), 225);
        run_phase(t_dt'($urandom()), t_rest'({$urandom(), $urandom()}), 225);

        repeat (80) @(posedge i_clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
